### hdl/pcd_pkg.sv
package pcd_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_ECHO_BLANK  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SHORT_LIMIT = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_LIMIT  = 2'd2;

   localparam logic [15:0] ECHO_BLANK_RESET  = 16'd100;
   localparam logic [15:0] SHORT_LIMIT_RESET = 16'd300;
   localparam logic [15:0] LONG_LIMIT_RESET  = 16'd1000;

   localparam logic [1:0] DIGIT_SHORT = 2'd1;
   localparam logic [1:0] DIGIT_LONG  = 2'd2;

   localparam logic STATUS_TIMEOUT  = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_BLANK  = 2'd1,
      PHASE_LISTEN = 2'd2
   } phase_type;

   typedef struct packed {
      logic pulse_seen;
   } req_word_type;

   typedef struct packed {
      logic [31:0] command_code;
      logic [3:0]  digit_count;
      logic        status;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] echo_blank_ticks;
      logic [15:0] short_limit_ticks;
      logic [15:0] long_limit_ticks;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } res_type;

endpackage

### hdl/pcd_chan_if.sv
interface pcd_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

### hdl/pcd_csr.sv
module pcd_csr
   import pcd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ECHO_BLANK:  cfg_in.echo_blank_ticks  = csr_wdata;
            CSR_SHORT_LIMIT: cfg_in.short_limit_ticks = csr_wdata;
            CSR_LONG_LIMIT:  cfg_in.long_limit_ticks  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_blank_ticks  <= ECHO_BLANK_RESET;
         cfg_ff.short_limit_ticks <= SHORT_LIMIT_RESET;
         cfg_ff.long_limit_ticks  <= LONG_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/pcd_seq.sv
module pcd_seq
   import pcd_pkg::*;
#(
   parameter int MAX_PULSES = 10
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  logic    pulse_seen,
   input  cfg_type cfg,
   output res_type res
);

   localparam logic [3:0] DigitLimit = 4'(MAX_PULSES - 1);

   phase_type   phase_ff, phase_in;
   logic [16:0] timer_ff, timer_in;
   logic [3:0]  digits_ff, digits_in;
   logic [31:0] code_ff, code_in;

   logic [16:0] timer_inc;
   logic [1:0]  digit;
   logic [31:0] code_sum;
   logic [31:0] code_next;
   logic [3:0]  digits_next;
   phase_type   blank_phase;

   always_comb begin
      timer_inc   = timer_ff + 17'd1;
      digit       = (timer_ff <= {1'b0, cfg.short_limit_ticks}) ? DIGIT_SHORT : DIGIT_LONG;
      code_sum    = code_ff + {30'd0, digit};
      code_next   = (code_sum << 3) + (code_sum << 1);
      digits_next = digits_ff + 4'd1;
      blank_phase = (cfg.echo_blank_ticks == 16'd0) ? PHASE_LISTEN : PHASE_BLANK;

      phase_in  = phase_ff;
      timer_in  = timer_ff;
      digits_in = digits_ff;
      code_in   = code_ff;
      res.valid             = 1'b0;
      res.word.command_code = code_ff;
      res.word.digit_count  = digits_ff;
      res.word.status       = STATUS_TIMEOUT;

      if (step_en) begin
         case (phase_ff)
            PHASE_BLANK: begin
               if (timer_inc >= {1'b0, cfg.echo_blank_ticks}) begin
                  phase_in = PHASE_LISTEN;
                  timer_in = 17'd0;
               end else begin
                  timer_in = timer_inc;
               end
            end
            PHASE_LISTEN: begin
               if (pulse_seen) begin
                  code_in   = code_next;
                  digits_in = digits_next;
                  timer_in  = 17'd0;
                  if (digits_next >= DigitLimit) begin
                     phase_in              = PHASE_IDLE;
                     res.valid             = 1'b1;
                     res.word.command_code = code_next;
                     res.word.digit_count  = digits_next;
                     res.word.status       = STATUS_OVERFLOW;
                  end else begin
                     phase_in = blank_phase;
                  end
               end else if (timer_ff >= {1'b0, cfg.long_limit_ticks}) begin
                  phase_in  = PHASE_IDLE;
                  timer_in  = 17'd0;
                  res.valid = 1'b1;
               end else begin
                  timer_in = timer_inc;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
               if (pulse_seen) begin
                  digits_in = 4'd0;
                  code_in   = 32'd0;
                  timer_in  = 17'd0;
                  phase_in  = blank_phase;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         timer_ff  <= 17'd0;
         digits_ff <= 4'd0;
         code_ff   <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         digits_ff <= digits_in;
         code_ff   <= code_in;
      end
   end

   // a result only ever comes out of the listen phase
   assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (phase_ff == PHASE_LISTEN))
      else $error("result outside listen phase");

   // every result returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      res.valid |=> (phase_ff == PHASE_IDLE) && (timer_ff == 17'd0))
      else $error("sequencer not idle after result");

   // overflow is reported exactly at the digit limit
   assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.word.status == STATUS_OVERFLOW) |-> (res.word.digit_count == DigitLimit))
      else $error("overflow at wrong digit count");

   // state holds when no word is processed
   assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(timer_ff) && $stable(code_ff))
      else $error("state moved without a word");

endmodule

### hdl/pulse_interval_command_decoder_unit.sv
// An accepted word is registered, then processed once the output register is free, and
// its result (if any) is registered in the output register and offered on rsp_chan.
// Throughput: one word per cycle, set by the state update loop, while no result waits.
// Output register lets a new word enter while a result waits on rsp_chan.
// Reset (synchronous, active high): idle phase, counters cleared, registers at defaults.
module pulse_interval_command_decoder_unit
   import pcd_pkg::*;
#(
   parameter int MAX_PULSES = 10
)
(
   input  logic                     clock,
   input  logic                     reset,
   pcd_chan_if.sink                 req_chan,
   pcd_chan_if.source               rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type      cfg;
   res_type      res;

   logic         in_valid_ff, in_valid_in;
   logic         in_pulse_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         out_free;
   logic         step_en;
   logic         req_take;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step_en  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   pcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcd_seq #(
      .MAX_PULSES (MAX_PULSES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .pulse_seen (in_pulse_ff),
      .cfg        (cfg),
      .res        (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en && res.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pulse_ff <= req_chan.word.pulse_seen;
      end
      if (step_en && res.valid) begin
         out_word_ff <= res.word;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word  = out_word_ff;

   // a result is never written over one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      (step_en && res.valid) |-> (!out_valid_ff || rsp_chan.ready))
      else $error("result word overwritten");

endmodule

### tb/tb.sv
module tb;
   import pcd_pkg::*;

   localparam int PulseLimit = 10;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   pcd_chan_if #(.word_type(req_word_type)) req_if ();
   pcd_chan_if #(.word_type(rsp_word_type)) rsp_if ();

   pulse_interval_command_decoder_unit #(
      .MAX_PULSES(PulseLimit)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   class command_scoreboard;
      logic [15:0]  blank_ticks;
      logic [15:0]  short_ticks;
      logic [15:0]  long_ticks;
      phase_type    phase;
      logic [16:0]  timer;
      logic [3:0]   digits;
      logic [31:0]  code;
      rsp_word_type pending_q[$];
      int           errors;
      int           ticks_seen;
      int           commands_made;
      int           overflows_made;
      int           results_checked;

      function new();
         blank_ticks     = ECHO_BLANK_RESET;
         short_ticks     = SHORT_LIMIT_RESET;
         long_ticks      = LONG_LIMIT_RESET;
         phase           = PHASE_IDLE;
         timer           = '0;
         digits          = '0;
         code            = '0;
         errors          = 0;
         ticks_seen      = 0;
         commands_made   = 0;
         overflows_made  = 0;
         results_checked = 0;
      endfunction

      function void set_reg(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] value);
         case (idx)
            CSR_ECHO_BLANK: begin
               blank_ticks = value;
            end
            CSR_SHORT_LIMIT: begin
               short_ticks = value;
            end
            CSR_LONG_LIMIT: begin
               long_ticks = value;
            end
            default: begin
            end
         endcase
      endfunction

      function void begin_blanking();
         timer = '0;
         phase = (blank_ticks == 16'd0) ? PHASE_LISTEN : PHASE_BLANK;
      endfunction

      function void end_command(input logic st);
         rsp_word_type done;
         done.command_code = code;
         done.digit_count  = digits;
         done.status       = st;
         pending_q.push_back(done);
         commands_made++;
         if (st == STATUS_OVERFLOW) begin
            overflows_made++;
         end
         phase = PHASE_IDLE;
         timer = '0;
      endfunction

      function void note_tick(input logic pulse);
         logic [1:0] digit;
         ticks_seen++;
         case (phase)
            PHASE_BLANK: begin
               timer = timer + 17'd1;
               if (timer >= {1'b0, blank_ticks}) begin
                  phase = PHASE_LISTEN;
                  timer = '0;
               end
            end
            PHASE_LISTEN: begin
               if (pulse) begin
                  digit  = (timer <= {1'b0, short_ticks}) ? DIGIT_SHORT : DIGIT_LONG;
                  code   = (code + {30'd0, digit}) * 32'd10;
                  digits = digits + 4'd1;
                  if (digits >= PulseLimit - 1) begin
                     end_command(STATUS_OVERFLOW);
                  end else begin
                     begin_blanking();
                  end
               end else if (timer >= {1'b0, long_ticks}) begin
                  end_command(STATUS_TIMEOUT);
               end else begin
                  timer = timer + 17'd1;
               end
            end
            default: begin
               phase = PHASE_IDLE;
               if (pulse) begin
                  digits = '0;
                  code   = '0;
                  begin_blanking();
               end
            end
         endcase
      endfunction

      function void check_result(input rsp_word_type got);
         rsp_word_type want;
         if (pending_q.size() == 0) begin
            $error("unexpected result word: code %0d count %0d status %0d",
                   got.command_code, got.digit_count, got.status);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         results_checked++;
         if (got.command_code !== want.command_code) begin
            $error("command_code: expected %0d, actual %0d", want.command_code,
                   got.command_code);
            errors++;
         end
         if (got.digit_count !== want.digit_count) begin
            $error("digit_count: expected %0d, actual %0d", want.digit_count,
                   got.digit_count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction

      function bit is_empty();
         return pending_q.size() == 0;
      endfunction

      function void flag_leftovers();
         if (pending_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_q.size());
            errors++;
         end
      endfunction
   endclass

   command_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int cfg_blank;
   int cfg_short;
   int cfg_long;
   int settings_used;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_result(rsp_if.word);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_word(input logic p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.word.pulse_seen <= p;
      do @(posedge clock); while (!req_if.ready);
      board.note_tick(p);
   endtask

   task automatic send_quiet(input int n);
      for (int i = 0; i < n; i++) begin
         send_word(1'b0);
      end
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) begin
         send_word(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (!board.is_empty() && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input int b, input int s, input int l);
      logic [CsrIndexWidth-1:0] idx[3];
      int                       vals[3];
      idx  = '{CSR_ECHO_BLANK, CSR_SHORT_LIMIT, CSR_LONG_LIMIT};
      vals = '{b, s, l};
      for (int i = 0; i < 3; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i][15:0];
         @(posedge clock);
         board.set_reg(idx[i], vals[i][15:0]);
      end
      csr_wr_en <= 1'b0;
      cfg_blank = b;
      cfg_short = s;
      cfg_long  = l;
      settings_used++;
   endtask

   // start pulse, digits at chosen gaps, then timeout unless the digits overflow
   task automatic send_command(input int ndigits);
      int gap;
      send_word(1'b1);
      for (int d = 0; d < ndigits; d++) begin
         send_noise(cfg_blank);
         case ($urandom_range(0, 4))
            0: gap = 0;
            1: gap = cfg_short;
            2: gap = cfg_short + 1;
            3: gap = cfg_long;
            default: gap = $urandom_range(0, cfg_long);
         endcase
         if (gap > cfg_long) begin
            gap = cfg_long;
         end
         send_quiet(gap);
         send_word(1'b1);
      end
      if (ndigits < PulseLimit - 1) begin
         send_noise(cfg_blank);
         send_quiet(cfg_long + 1);
      end
   endtask

   task automatic run_setting(input int b, input int s, input int l, input int min_words,
                              input int min_results);
      int words_start;
      int results_start;
      write_config(b, s, l);
      words_start   = board.ticks_seen;
      results_start = board.commands_made;
      while (board.ticks_seen - words_start < min_words ||
             board.commands_made - results_start < min_results) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise($urandom_range(1, 20));
         end else begin
            send_quiet($urandom_range(0, 3));
            send_command($urandom_range(0, PulseLimit - 1));
         end
      end
      drain_results();
   endtask

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      board         = new();
      settings_used = 0;
      send_idle_pct = 24;
      recv_idle_pct = 76;
      reset                  <= 1'b1;
      csr_wr_en              <= 1'b0;
      csr_index              <= CSR_ECHO_BLANK;
      csr_wdata              <= '0;
      req_if.valid           <= 1'b0;
      req_if.word.pulse_seen <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: blanking of 2, digit 1 at elapsed 0 and 3, digit 2 at 6, timeout
      write_config(2, 3, 6);
      send_quiet(1);
      send_word(1'b1);
      send_word(1'b1);
      send_word(1'b1);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b1);
      send_quiet(3);
      send_word(1'b1);
      send_quiet(2);
      send_quiet(6);
      send_word(1'b1);
      send_quiet(2);
      send_quiet(7);
      drain_results();

      run_setting(3, 5, 12, 220, 4);
      run_setting(0, 0, 0, 220, 4);

      send_idle_pct = 76;
      recv_idle_pct = 24;
      run_setting(1, 20, 8, 220, 4);
      run_setting(5, 2, 15, 220, 4);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_setting(0, 10, 10, 220, 4);
      run_setting(2, 4, 9, 220, 4);

      // widest registers: long blanking cut short by a write mid-command,
      // then wide limits with back to back pulses up to overflow
      write_config(65535, 65535, 65535);
      send_word(1'b1);
      send_quiet(5);
      drain_results();
      write_config(0, 65535, 65535);
      send_quiet(2);
      repeat (PulseLimit - 1) send_word(1'b1);
      drain_results();

      board.flag_leftovers();
      $display("Run covered %0d tick words over %0d register settings.",
               board.ticks_seen, settings_used);
      $display("%0d commands predicted (%0d overflow), %0d results checked.",
               board.commands_made, board.overflows_made, board.results_checked);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
